// ===== hw/rtl/ftit_pkg.sv =====
// shared types and constants for the fused track id table
`default_nettype none

package ftit_pkg;

	// width of a fused track id and of the id counter
	localparam int unsigned TRACK_W = 16;

	// request kinds carried in the input tuser
	typedef enum logic [1:0] {
		CMD_LASER  = 2'd0,
		CMD_CAMERA = 2'd1,
		CMD_PAIR   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fused_track_id_table.sv =====
// fused track id table: association memory with first-match scan and append
//
//  channel | direction | handshake           | payload
//  s_*     | in        | s_tvalid / s_tready | tuser: command, tdata: laser_id, camera_id
//  m_*     | out       | m_tvalid / m_tready | tdata: fused_id, tuser: created, table_full
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_data: id_base, taken only while idle
//
// on a miss the scan reads every entry below the entry count, then appends or flags
// table_full; a hit ends it at the first match, an empty table appends at once and an
// unused command skips it; the scan reads one entry a cycle through the single read port.
// reset clears the entry count and loads the id counter with zero; the memory
// itself is not cleared, only entries below the count are ever compared.
// the next word can be taken in the cycle after the result is presented, while it still
// waits in the output register; a stalled output holds the next result in its final state.
`default_nettype none

module fused_track_id_table #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned OBJ_ID_BITS = 8,
	localparam int unsigned IN_TDATA_W = ((2 * OBJ_ID_BITS + 7) / 8) * 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input words
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [IN_TDATA_W-1:0]        s_tdata,   // laser_id, camera_id
	input  wire logic [1:0]                   s_tuser,   // command
	// result words
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [ftit_pkg::TRACK_W-1:0]      m_tdata,   // fused_id
	output logic [1:0]                        m_tuser,   // created, table_full
	// id_base register
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [ftit_pkg::TRACK_W-1:0] cfg_data
);

	localparam int unsigned SLOT_W     = OBJ_ID_BITS + 1;
	localparam int unsigned ENT_W      = 2 * SLOT_W + ftit_pkg::TRACK_W;
	localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                        state_q;
	ftit_pkg::cmd_t                cmd_q;
	logic [OBJ_ID_BITS-1:0]        lid_q;
	logic [OBJ_ID_BITS-1:0]        cid_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              rd_idx_q;
	logic [ftit_pkg::TRACK_W-1:0]  last_given_q;
	logic [ftit_pkg::TRACK_W-1:0]  res_fused_q;
	logic                          res_created_q;
	logic                          res_full_q;

	// read pipeline stage
	logic                          rd_vld_s1;
	logic [IDX_W-1:0]              chk_idx_s1;
	logic [ENT_W-1:0]              rd_data_s1;

	// entry memory
	logic [ENT_W-1:0]              mem [TABLE_DEPTH];

	logic                          s_acc;
	logic                          more;
	logic                          want_l;
	logic                          want_c;
	logic [SLOT_W-1:0]             ent_laser;
	logic [SLOT_W-1:0]             ent_camera;
	logic [ftit_pkg::TRACK_W-1:0]  ent_track;
	logic                          hit_s1;
	logic                          miss_done;
	logic                          tbl_full;
	logic [ftit_pkg::TRACK_W-1:0]  next_id;
	logic                          mem_we;
	logic [IDX_W-1:0]              mem_waddr;
	logic [ENT_W-1:0]              mem_wdata;
	logic [SLOT_W-1:0]             new_laser;
	logic [SLOT_W-1:0]             new_camera;
	logic                          out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;

	// fields of the entry just read
	assign ent_laser  = rd_data_s1[SLOT_W-1:0];
	assign ent_camera = rd_data_s1[2*SLOT_W-1:SLOT_W];
	assign ent_track  = rd_data_s1[ENT_W-1:2*SLOT_W];

	// which ids take part in the compare
	always_comb begin
		case (cmd_q)
			ftit_pkg::CMD_LASER: begin
				want_l = 1'b1;
				want_c = 1'b0;
			end
			ftit_pkg::CMD_CAMERA: begin
				want_l = 1'b0;
				want_c = 1'b1;
			end
			ftit_pkg::CMD_PAIR: begin
				want_l = 1'b1;
				want_c = 1'b1;
			end
			default: begin
				want_l = 1'b0;
				want_c = 1'b0;
			end
		endcase
	end

	// match and scan progress
	assign more      = (rd_idx_q < count_q);
	assign hit_s1    = rd_vld_s1 &&
		((want_l && ent_laser == {1'b1, lid_q}) || (want_c && ent_camera == {1'b1, cid_q}));
	assign miss_done = !rd_vld_s1 && !more;
	assign tbl_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign next_id   = last_given_q + ftit_pkg::TRACK_W'(1);

	// ids written on a pair hit or an append
	assign new_laser  = (cmd_q != ftit_pkg::CMD_CAMERA) ? {1'b1, lid_q} : '0;
	assign new_camera = (cmd_q != ftit_pkg::CMD_LASER)  ? {1'b1, cid_q} : '0;

	// write-back port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = {next_id, new_camera, new_laser};
		if (state_q == ST_SCAN) begin
			if (hit_s1) begin
				mem_we    = (cmd_q == ftit_pkg::CMD_PAIR);
				mem_waddr = chk_idx_s1;
				mem_wdata = {ent_track, new_camera, new_laser};
			end else if (miss_done && !tbl_full) begin
				mem_we = 1'b1;
			end
		end
	end

	// entry memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
	end

	// request capture, scan sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			last_given_q  <= '0;
			rd_idx_q      <= '0;
			rd_vld_s1     <= 1'b0;
			m_tvalid      <= 1'b0;
			cmd_q         <= ftit_pkg::CMD_NOP;
			lid_q         <= '0;
			cid_q         <= '0;
			chk_idx_s1    <= '0;
			res_fused_q   <= '0;
			res_created_q <= 1'b0;
			res_full_q    <= 1'b0;
			m_tdata       <= '0;
			m_tuser       <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_EMIT) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				last_given_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					rd_idx_q  <= '0;
					rd_vld_s1 <= 1'b0;
					if (s_acc) begin
						cmd_q         <= ftit_pkg::cmd_t'(s_tuser);
						lid_q         <= s_tdata[OBJ_ID_BITS-1:0];
						cid_q         <= s_tdata[2*OBJ_ID_BITS-1:OBJ_ID_BITS];
						res_fused_q   <= '0;
						res_created_q <= 1'b0;
						res_full_q    <= 1'b0;
						if (ftit_pkg::cmd_t'(s_tuser) == ftit_pkg::CMD_NOP) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// issue the next read while the previous one is checked
					rd_vld_s1  <= more && !hit_s1;
					chk_idx_s1 <= rd_idx_q[IDX_W-1:0];
					if (more) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (hit_s1) begin
						res_fused_q <= ent_track;
						state_q     <= ST_EMIT;
					end else if (miss_done) begin
						if (tbl_full) begin
							res_full_q <= 1'b1;
						end else begin
							res_fused_q   <= next_id;
							res_created_q <= 1'b1;
							last_given_q  <= next_id;
							count_q       <= count_q + CNT_W'(1);
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= res_fused_q;
						m_tuser  <= {res_full_q, res_created_q};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ftit_checker.sv =====
// port-level checks for the fused track id table, bound to the top level
`default_nettype none

module ftit_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tvalid,
	input wire logic                         s_tready,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [ftit_pkg::TRACK_W-1:0] m_tdata,
	input wire logic [1:0]                   m_tuser
);

	logic [1:0] pend_q;
	logic       s_acc;
	logic       m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// words taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, s_acc} - {1'b0, m_acc};
		end
	end

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// created and table_full never together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("created and table_full both set");

	// a full table answers id zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0)
		else $error("table_full with non-zero fused id");

	// every result belongs to an accepted word
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc |-> pend_q != 2'd0)
		else $error("result without a pending request");

	// at most one word in the scan and one in the output register
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests in flight");

endmodule

bind fused_track_id_table ftit_checker u_ftit_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the fused track id table with its own table predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int RANDOM_WORDS = 412;

	// one detection as it travels on the input stream
	typedef struct packed {
		ftit_pkg::cmd_t cmd;
		logic [7:0]     camera;
		logic [7:0]     laser;
	} det_t;

	// one answer of the table
	typedef struct packed {
		logic [ftit_pkg::TRACK_W-1:0] fused;
		logic                         created;
		logic                         full;
	} track_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [15:0]                   s_tdata = '0;   // laser_id, camera_id
	logic [1:0]                    s_tuser = '0;   // command
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [ftit_pkg::TRACK_W-1:0]  m_tdata;        // fused_id
	logic [1:0]                    m_tuser;        // created, table_full
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [ftit_pkg::TRACK_W-1:0]  cfg_data = '0;

	// predicted association table
	logic [8:0]                    tbl_laser [DEPTH];
	logic [8:0]                    tbl_camera [DEPTH];
	logic [ftit_pkg::TRACK_W-1:0]  tbl_track [DEPTH];
	int unsigned                   tbl_count = 0;
	logic [ftit_pkg::TRACK_W-1:0]  last_track = '0;

	det_t                det_q [$];
	track_t              track_due [$];
	bit                  in_fire = 1'b0;
	int unsigned         send_idle = 0;
	int unsigned         recv_stall = 0;
	int unsigned         mismatches = 0;

	fused_track_id_table #(
		.TABLE_DEPTH(DEPTH),
		.OBJ_ID_BITS(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// first-match lookup, pair rewrite and append on miss
	function automatic track_t resolve_track(det_t d);
		track_t r;
		int     pos;
		bit     hit_l;
		bit     hit_c;
		r = '0;
		pos = -1;
		if (d.cmd == ftit_pkg::CMD_NOP) begin
			return r;
		end
		for (int i = 0; i < tbl_count; i++) begin
			hit_l = (d.cmd != ftit_pkg::CMD_CAMERA) && (tbl_laser[i] == {1'b1, d.laser});
			hit_c = (d.cmd != ftit_pkg::CMD_LASER) && (tbl_camera[i] == {1'b1, d.camera});
			if (pos < 0 && (hit_l || hit_c)) begin
				pos = i;
			end
		end
		if (pos >= 0) begin
			if (d.cmd == ftit_pkg::CMD_PAIR) begin
				tbl_laser[pos] = {1'b1, d.laser};
				tbl_camera[pos] = {1'b1, d.camera};
			end
			r.fused = tbl_track[pos];
		end else if (tbl_count >= DEPTH) begin
			r.full = 1'b1;
		end else begin
			last_track = last_track + 1'b1;
			tbl_laser[tbl_count] =
				(d.cmd != ftit_pkg::CMD_CAMERA) ? {1'b1, d.laser} : 9'd0;
			tbl_camera[tbl_count] =
				(d.cmd != ftit_pkg::CMD_LASER) ? {1'b1, d.camera} : 9'd0;
			tbl_track[tbl_count] = last_track;
			tbl_count++;
			r.fused = last_track;
			r.created = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
		end
	endtask

	// input driver and output back-pressure, changed on the falling edge
	always @(negedge clk) begin : driver
		det_t w;
		if (arst_n) begin
			if (!s_tvalid || in_fire) begin
				if (det_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					w = det_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {w.camera, w.laser};
					s_tuser <= w.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// monitor: predict on each accepted word, check each result word
	always @(posedge clk) begin : monitor
		track_t due;
		in_fire = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (track_due.size() == 0) begin
				report_mismatch("unexpected result, fused_id", m_tdata, -1);
			end else begin
				due = track_due.pop_front();
				if (m_tdata !== due.fused)
					report_mismatch("fused_id", m_tdata, due.fused);
				if (m_tuser[0] !== due.created)
					report_mismatch("created", m_tuser[0], due.created);
				if (m_tuser[1] !== due.full)
					report_mismatch("table_full", m_tuser[1], due.full);
			end
		end
		if (in_fire) begin
			track_due.insert(track_due.size(),
				resolve_track(det_t'{cmd: ftit_pkg::cmd_t'(s_tuser),
				camera: s_tdata[15:8], laser: s_tdata[7:0]}));
		end
	end

	task automatic queue_det(ftit_pkg::cmd_t c, logic [7:0] l, logic [7:0] cam);
		det_q.insert(det_q.size(), det_t'{cmd: c, camera: cam, laser: l});
	endtask

	// wait until every queued word went in and every result came out
	task automatic drain();
		while (det_q.size() != 0 || s_tvalid || track_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_id_base(logic [ftit_pkg::TRACK_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		last_track = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random detection: mostly ids already in the table, some fresh ones
	function automatic det_t make_det(int unsigned miss_pct);
		det_t        d;
		int unsigned k;
		d.laser = 8'($urandom);
		d.camera = 8'($urandom);
		if ($urandom_range(99) < 6) begin
			d.cmd = ftit_pkg::CMD_NOP;
		end else if (tbl_count == 0 || $urandom_range(99) < miss_pct) begin
			d.cmd = ftit_pkg::cmd_t'($urandom_range(2));
		end else begin
			k = $urandom_range(tbl_count - 1);
			if (tbl_laser[k][8] && (!tbl_camera[k][8] || $urandom_range(1))) begin
				d.laser = tbl_laser[k][7:0];
				d.cmd = $urandom_range(1) ? ftit_pkg::CMD_LASER : ftit_pkg::CMD_PAIR;
			end else begin
				d.camera = tbl_camera[k][7:0];
				d.cmd = $urandom_range(1) ? ftit_pkg::CMD_CAMERA : ftit_pkg::CMD_PAIR;
			end
		end
		return d;
	endfunction

	// stimulus and verdict
	initial begin : stimulus
		logic [ftit_pkg::TRACK_W-1:0] bases [4];
		bases = '{16'hFFFF, 16'h0000, 16'h0000, 16'h8000};
		bases[2] = 16'($urandom);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: counter wrap, absent ids, pair rewrite, unused command
		write_id_base(16'hFFFE);
		queue_det(ftit_pkg::CMD_CAMERA, 8'hFF, 8'h00);
		queue_det(ftit_pkg::CMD_LASER, 8'h00, 8'hFF);
		queue_det(ftit_pkg::CMD_LASER, 8'h00, 8'h00);
		queue_det(ftit_pkg::CMD_CAMERA, 8'h00, 8'h00);
		queue_det(ftit_pkg::CMD_LASER, 8'hFF, 8'hFF);
		queue_det(ftit_pkg::CMD_CAMERA, 8'h00, 8'hFF);
		queue_det(ftit_pkg::CMD_PAIR, 8'hFF, 8'h00);
		queue_det(ftit_pkg::CMD_LASER, 8'hFF, 8'h00);
		queue_det(ftit_pkg::CMD_NOP, 8'hFF, 8'hFF);
		queue_det(ftit_pkg::CMD_NOP, 8'h00, 8'h00);
		queue_det(ftit_pkg::CMD_PAIR, 8'h55, 8'hAA);
		queue_det(ftit_pkg::CMD_PAIR, 8'hAA, 8'h55);
		queue_det(ftit_pkg::CMD_LASER, 8'hAA, 8'h00);
		queue_det(ftit_pkg::CMD_CAMERA, 8'h00, 8'hAA);
		queue_det(ftit_pkg::CMD_PAIR, 8'h55, 8'h55);
		queue_det(ftit_pkg::CMD_CAMERA, 8'h00, 8'h55);
		drain();

		// random phases with different idling and id bases; the last fills the table
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 84; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 84; end
				default: begin send_idle = 38; recv_stall = 38; end
			endcase
			write_id_base(bases[ph]);
			for (int n = 0; n < RANDOM_WORDS; n++) begin
				while (det_q.size() >= 2)
					@(negedge clk);
				det_q.insert(det_q.size(), make_det((ph == 3) ? 25 : 4));
			end
			drain();
		end

		repeat (DEPTH + 8) @(negedge clk);
		if (mismatches == 0) begin
			$display("fused_track_id_table regression: pass");
		end else begin
			$display("fused_track_id_table regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#(30_000_000);
		$display("fused_track_id_table regression: fail");
		$finish;
	end

endmodule

// ===== fused_track_id_table.f =====
hw/rtl/ftit_pkg.sv
hw/rtl/fused_track_id_table.sv
hw/rtl/ftit_checker.sv
sim/testbench.sv
